// ===== hdl/las_pkg.sv =====
// ----------------------------------------------------------------------------
// LED animation sequencer package
// Shared types, mode codes, register indexes and pattern tables.
// ----------------------------------------------------------------------------
package las_pkg;

  localparam int unsigned FUNC_W  = 3;
  localparam int unsigned TICK_W  = 32;
  localparam int unsigned STEP_W  = 16;
  localparam int unsigned COUNT_W = 8;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [STEP_W-1:0] SLOW_STEP_RST   = STEP_W'(500);
  localparam logic [STEP_W-1:0] MEDIUM_STEP_RST = STEP_W'(200);
  localparam logic [STEP_W-1:0] FAST_STEP_RST   = STEP_W'(100);

  typedef enum logic [FUNC_W-1:0] {
    FUNC_RESET     = 3'd0,
    FUNC_SUCCESS   = 3'd1,
    FUNC_WAITING   = 3'd2,
    FUNC_RECEIVING = 3'd3,
    FUNC_SYNC      = 3'd4,
    FUNC_WRITING   = 3'd5,
    FUNC_FAIL      = 3'd6,
    FUNC_OTHER     = 3'd7
  } las_func_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SLOW_STEP   = 2'd0,
    CFG_MEDIUM_STEP = 2'd1,
    CFG_FAST_STEP   = 2'd2,
    CFG_UNUSED      = 2'd3
  } las_cfg_idx_t;

  // LED triple, packed as hold, ping, rev.
  typedef struct packed {
    logic hold;
    logic ping;
    logic rev;
  } las_leds_t;

  typedef struct packed {
    logic [COUNT_W-1:0] step_count;
    logic [TICK_W-1:0]  last_tick;
    las_leds_t          leds;
  } las_state_t;

  typedef struct packed {
    logic [STEP_W-1:0] slow;
    logic [STEP_W-1:0] moderate;
    logic [STEP_W-1:0] fast;
  } las_step_cfg_t;

  // Pattern of a mode at a given step; only the low two bits of the step matter.
  function automatic las_leds_t pattern_of(input las_func_t func,
                                           input logic [1:0] idx);
    las_leds_t p;
    p = '0;
    unique case (func)
      FUNC_SUCCESS: begin
        unique case (idx)
          2'd0:    p = 3'b100;
          2'd1:    p = 3'b010;
          2'd2:    p = 3'b001;
          default: p = 3'b010;
        endcase
      end
      FUNC_WAITING:   p = idx[0] ? 3'b000 : 3'b111;
      FUNC_RECEIVING: p = idx[0] ? 3'b001 : 3'b010;
      FUNC_WRITING:   p = idx[0] ? 3'b010 : 3'b101;
      FUNC_FAIL:      p = idx[0] ? 3'b000 : 3'b001;
      default:        p = '0;
    endcase
    return p;
  endfunction

endpackage

// ===== hdl/las_step.sv =====
// ----------------------------------------------------------------------------
// LED animation sequencer step logic
// Combinational next state for one poll: pattern select, then step check.
// ----------------------------------------------------------------------------
module las_step
  import las_pkg::*;
(
  input  las_state_t         state_cur,
  input  las_step_cfg_t      step_cfg,
  input  logic [FUNC_W-1:0]  func,
  input  logic [TICK_W-1:0]  now_ticks,
  output las_state_t         state_new
);

  las_func_t          mode;
  las_state_t         mid;
  logic [STEP_W-1:0]  step_limit;
  logic [TICK_W-1:0]  elapsed;
  logic               in_range;

  assign mode = las_func_t'(func);

  // Pattern stage: LEDs and counter as the mode selects them.
  always_comb begin
    mid        = state_cur;
    step_limit = step_cfg.slow;
    in_range   = 1'b0;
    unique case (mode)
      FUNC_RESET: begin
        mid.leds       = '0;
        mid.step_count = '0;
        mid.last_tick  = now_ticks;
      end
      FUNC_SUCCESS, FUNC_WAITING, FUNC_RECEIVING, FUNC_WRITING, FUNC_FAIL: begin
        if (mode == FUNC_RECEIVING) begin
          step_limit = step_cfg.moderate;
        end else if (mode == FUNC_WRITING || mode == FUNC_FAIL) begin
          step_limit = step_cfg.fast;
        end
        if (mode == FUNC_SUCCESS) begin
          in_range = (state_cur.step_count < COUNT_W'(4));
        end else begin
          in_range = (state_cur.step_count < COUNT_W'(2));
        end
        if (in_range) begin
          mid.leds = pattern_of(mode, state_cur.step_count[1:0]);
        end else begin
          mid.step_count = '0;
        end
      end
      FUNC_SYNC: begin
        step_limit = step_cfg.fast;
        if (state_cur.step_count == COUNT_W'(0)) begin
          mid.leds.hold = 1'b1;
        end else if (state_cur.step_count == COUNT_W'(1)) begin
          mid.leds.hold = 1'b0;
        end else begin
          mid.step_count = '0;
        end
      end
      default: ;
    endcase
  end

  // Step check on the wrapping elapsed time.
  assign elapsed = now_ticks - mid.last_tick;

  always_comb begin
    state_new = mid;
    if (elapsed > TICK_W'(step_limit)) begin
      state_new.step_count = mid.step_count + COUNT_W'(1);
      state_new.last_tick  = now_ticks;
    end
  end

endmodule

// ===== hdl/led_animation_sequencer_top.sv =====
// ----------------------------------------------------------------------------
// LED animation sequencer
// Poll-driven LED pattern sequencer with three configurable step times.
// ----------------------------------------------------------------------------
// Each request on the input channel is one poll carrying a mode and the
// current tick; it produces exactly one result holding the three LED states
// after that poll. A poll not stalled is taken in the cycle it is offered and
// the state is updated at that same edge, so one poll per clock is sustained
// while the input does not stall. The critical path is the 32-bit elapsed-time
// subtraction followed by the compare against the mode's step time. An output
// register backed by a one-entry skid register lets a new poll be taken while
// a finished result still waits; the input stalls only while the skid register
// is occupied. Step times are written on the configuration port, which is
// always ready; writes to index 3 are ignored.
// ----------------------------------------------------------------------------
module led_animation_sequencer_top
  import las_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  // Poll requests
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [FUNC_W-1:0]    in_func,
  input  logic [TICK_W-1:0]    in_now_ticks,
  // LED results
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_hold_led,
  output logic                 out_ping_led,
  output logic                 out_rev_led,
  // Configuration writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [STEP_W-1:0]    cfg_data
);

  las_step_cfg_t step_cfg_r;
  las_state_t    state_r;
  las_state_t    state_nxt;

  las_leds_t     out_leds_r;
  logic          out_valid_r;
  las_leds_t     skid_leds_r;
  logic          skid_valid_r;

  logic          in_take;
  logic          out_take;

  // The configuration port never back-pressures.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_cfg_r.slow     <= SLOW_STEP_RST;
      step_cfg_r.moderate <= MEDIUM_STEP_RST;
      step_cfg_r.fast     <= FAST_STEP_RST;
    end else if (cfg_valid) begin
      unique case (las_cfg_idx_t'(cfg_index))
        CFG_SLOW_STEP:   step_cfg_r.slow     <= cfg_data;
        CFG_MEDIUM_STEP: step_cfg_r.moderate <= cfg_data;
        CFG_FAST_STEP:   step_cfg_r.fast     <= cfg_data;
        default: ;
      endcase
    end
  end

  // The sequencer state moves once per accepted poll.
  las_step u_step (
    .state_cur (state_r),
    .step_cfg  (step_cfg_r),
    .func      (in_func),
    .now_ticks (in_now_ticks),
    .state_new (state_nxt)
  );

  assign in_stall = skid_valid_r;
  assign in_take  = in_valid && !in_stall;
  assign out_take = out_valid_r && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (in_take) begin
      state_r <= state_nxt;
    end
  end

  // Output register plus skid register. A new result lands in the output
  // register when it is free or being emptied, otherwise in the skid register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_take) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end
    end else if (in_take) begin
      if (!out_valid_r || out_take) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (out_take) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_take) begin
        out_leds_r <= skid_leds_r;
      end
    end else if (in_take) begin
      if (!out_valid_r || out_take) begin
        out_leds_r <= state_nxt.leds;
      end else begin
        skid_leds_r <= state_nxt.leds;
      end
    end
  end

  assign out_valid    = out_valid_r;
  assign out_hold_led = out_leds_r.hold;
  assign out_ping_led = out_leds_r.ping;
  assign out_rev_led  = out_leds_r.rev;

`ifndef NO_ASSERTIONS
  // The skid register is only ever filled behind a waiting output.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid register holds a result while the output is empty");

  // A reset-mode poll leaves the counter cleared and all LEDs off.
  a_reset_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (in_take && in_func == FUNC_RESET) |=>
      (state_r.step_count == '0 && state_r.leds == '0))
    else $error("reset mode did not clear the sequencer");

  // The sequencer state changes only when a poll is taken.
  a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !in_take |=> $stable(state_r))
    else $error("sequencer state changed without a poll");
`endif

endmodule

// ===== verif/led_animation_sequencer_top_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LED animation sequencer testbench
// Drives polls through the sequencer and checks every LED result it returns.
// ----------------------------------------------------------------------------
// The test runs in phases. A short directed sequence walks each animation mode
// through its patterns, across the step-time boundary and over the 32-bit
// tick wrap. Random phases follow, each under its own step-time setting and
// its own idling behaviour on both channels. The predictor below keeps its own
// copy of the step counter, the tick of the last step, the LED states and the
// step-time registers. Each accepted poll is run through it, and the expected
// LED triple joins a queue. Each result the block returns is compared with the
// oldest entry of that queue.
// ----------------------------------------------------------------------------
module led_animation_sequencer_top_test;
  import las_pkg::*;

  // A cycle with no accepted request on any channel counts towards this.
  localparam int unsigned STALL_LIMIT = 5000;
  localparam int unsigned HOLD_OFF_CYCLES = 80;

  typedef struct {
    las_func_t         func;
    logic [TICK_W-1:0] now;
  } poll_req_t;

  // Clock and reset.
  logic clk = 1'b0;
  logic rst_n = 1'b0;

  // Block ports. Every input is given a known value from time zero.
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [FUNC_W-1:0]    in_func = '0;
  logic [TICK_W-1:0]    in_now_ticks = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 out_hold_led;
  logic                 out_ping_led;
  logic                 out_rev_led;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [STEP_W-1:0]    cfg_data = '0;

  // Polls waiting to be offered, and LED triples still owed by the block.
  poll_req_t poll_q[$];
  las_leds_t led_q[$];

  // Predictor state and its copy of the step-time registers.
  logic [COUNT_W-1:0] pr_count;
  logic [TICK_W-1:0]  pr_last;
  las_leds_t          pr_leds;
  logic [STEP_W-1:0]  pr_slow;
  logic [STEP_W-1:0]  pr_medium;
  logic [STEP_W-1:0]  pr_fast;

  // Idling percentages for the current phase, and the receiver's hold-off.
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  bit          hold_req = 1'b0;
  bit          hold_started = 1'b0;
  int unsigned hold_left = 0;

  // Handshake flags, refreshed at every rising edge.
  logic in_taken = 1'b0;
  logic cfg_taken = 1'b0;

  // Bookkeeping.
  int unsigned mismatches = 0;
  int unsigned polls_taken = 0;
  int unsigned results_checked = 0;
  int unsigned cfg_writes = 0;
  int unsigned quiet_cycles = 0;
  logic [TICK_W-1:0] tick_cur = '0;

  led_animation_sequencer_top i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_func      (in_func),
    .in_now_ticks (in_now_ticks),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_hold_led (out_hold_led),
    .out_ping_led (out_ping_led),
    .out_rev_led  (out_rev_led),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // 12 ns period.
  always begin
    #6 clk = 1'b1;
    #6 clk = 0;
  end

  // Works out the LED triple that one poll leaves behind and moves the
  // predictor state on. The pattern for the current step is applied first;
  // only then is the elapsed time compared with the mode's step time.
  function automatic las_leds_t predict_poll(input las_func_t func,
                                             input logic [TICK_W-1:0] now);
    logic [STEP_W-1:0] step_len;
    logic [TICK_W-1:0] elapsed;
    int unsigned       n_pats;
    step_len = pr_slow;
    n_pats = 0;
    case (func)
      FUNC_RESET: begin
        pr_leds = '0;
        pr_last = now;
        pr_count = '0;
      end
      FUNC_SUCCESS: n_pats = 4;
      FUNC_WAITING: n_pats = 2;
      FUNC_RECEIVING: begin
        step_len = pr_medium;
        n_pats = 2;
      end
      FUNC_SYNC: begin
        // Only the hold LED follows the sync pattern.
        step_len = pr_fast;
        if (pr_count == 0) begin
          pr_leds.hold = 1'b1;
        end else if (pr_count == 1) begin
          pr_leds.hold = 1'b0;
        end else begin
          pr_count = '0;
        end
      end
      FUNC_WRITING, FUNC_FAIL: begin
        step_len = pr_fast;
        n_pats = 2;
      end
      default: ;
    endcase
    if (n_pats != 0) begin
      if (pr_count < n_pats) begin
        case (func)
          FUNC_SUCCESS: begin
            case (pr_count[1:0])
              2'd0:    pr_leds = 3'b100;
              2'd1:    pr_leds = 3'b010;
              2'd2:    pr_leds = 3'b001;
              default: pr_leds = 3'b010;
            endcase
          end
          FUNC_WAITING:   pr_leds = pr_count[0] ? 3'b000 : 3'b111;
          FUNC_RECEIVING: pr_leds = pr_count[0] ? 3'b001 : 3'b010;
          FUNC_WRITING:   pr_leds = pr_count[0] ? 3'b010 : 3'b101;
          default:        pr_leds = pr_count[0] ? 3'b000 : 3'b001;
        endcase
      end else begin
        // Past the last pattern: restart the count, LEDs stay as they are.
        pr_count = '0;
      end
    end
    elapsed = now - pr_last;
    if (elapsed > {{(TICK_W-STEP_W){1'b0}}, step_len}) begin
      pr_count = pr_count + 1'b1;
      pr_last = now;
    end
    return pr_leds;
  endfunction

  // Poll driver. A request that has not been taken is held unchanged; once it
  // has been taken the next one is offered, or the channel idles.
  always @(negedge clk) begin : drive_polls
    poll_req_t req;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (poll_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        req = poll_q.pop_front();
        in_valid <= 1'b1;
        in_func <= req.func;
        in_now_ticks <= req.now;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result receiver. A hold-off request stalls the output until the hold-off
  // count kept here runs out; otherwise the stall follows the phase's odds.
  always @(negedge clk) begin
    if (hold_req && !hold_started) begin
      hold_left = HOLD_OFF_CYCLES;
      hold_started = 1'b1;
    end
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Port monitor: predicts on each accepted poll, mirrors each accepted
  // register write and checks each accepted result against the oldest
  // expectation.
  always @(posedge clk) begin : watch_ports
    las_leds_t want;
    if (!rst_n) begin
      in_taken <= 1'b0;
      cfg_taken <= 1'b0;
    end else begin
      in_taken <= in_valid && !in_stall;
      cfg_taken <= cfg_valid && cfg_ready;
      if (in_valid && !in_stall) begin
        led_q.push_back(predict_poll(las_func_t'(in_func), in_now_ticks));
        polls_taken++;
      end
      if (cfg_valid && cfg_ready) begin
        case (las_cfg_idx_t'(cfg_index))
          CFG_SLOW_STEP:   pr_slow = cfg_data;
          CFG_MEDIUM_STEP: pr_medium = cfg_data;
          CFG_FAST_STEP:   pr_fast = cfg_data;
          default: ;
        endcase
        cfg_writes++;
      end
      if (out_valid && !out_stall) begin
        if (led_q.size() == 0) begin
          $display("%0t: LED result with nothing expected, got hold/ping/rev %b%b%b",
                   $time, out_hold_led, out_ping_led, out_rev_led);
          mismatches++;
        end else begin
          want = led_q.pop_front();
          if ({out_hold_led, out_ping_led, out_rev_led} !== want) begin
            $display("%0t: LED mismatch, expected hold/ping/rev %b%b%b, got %b%b%b",
                     $time, want.hold, want.ping, want.rev,
                     out_hold_led, out_ping_led, out_rev_led);
            mismatches++;
          end
          results_checked++;
        end
      end
    end
  end

  // Watchdog: ends the run if no request moves on any channel for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
          (cfg_valid && cfg_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles = quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no request accepted for %0d cycles", $time, quiet_cycles);
        $display("led_animation_sequencer_top_test: FAIL");
        $finish;
      end
    end
  end

  task automatic queue_poll(input las_func_t func, input logic [TICK_W-1:0] now);
    poll_req_t req;
    req.func = func;
    req.now = now;
    poll_q.push_back(req);
  endtask

  // Waits until every poll has been offered and taken and every result has
  // come back, then lets the output register settle.
  task automatic wait_drained();
    while (poll_q.size() != 0 || in_valid || led_q.size() != 0) begin
      @(negedge clk);
    end
    repeat (2) @(negedge clk);
  endtask

  task automatic write_step_reg(input las_cfg_idx_t idx, input logic [STEP_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do begin
      @(negedge clk);
    end while (!cfg_taken);
    cfg_valid <= 1'b0;
  endtask

  task automatic write_step_times(input logic [STEP_W-1:0] slow,
                                  input logic [STEP_W-1:0] medium_len,
                                  input logic [STEP_W-1:0] fast);
    write_step_reg(CFG_SLOW_STEP, slow);
    write_step_reg(CFG_MEDIUM_STEP, medium_len);
    write_step_reg(CFG_FAST_STEP, fast);
  endtask

  // Random polls, mostly as runs of one mode on a tick that moves forward by
  // amounts around the mode's step time, so that the patterns really cycle.
  // A few polls jump to an arbitrary tick or carry an arbitrary mode.
  task automatic queue_random_polls(input int unsigned n_polls);
    int unsigned made;
    int unsigned run_len;
    int unsigned span_max;
    las_func_t   func;
    las_func_t   this_func;
    logic [TICK_W-1:0] delta;
    made = 0;
    while (made < n_polls) begin
      if ($urandom_range(99) < 6) begin
        func = FUNC_RESET;
        run_len = 1;
      end else begin
        func = las_func_t'($urandom_range(7));
        run_len = $urandom_range(1, 12);
      end
      case (func)
        FUNC_RECEIVING:                    span_max = 2 * pr_medium + 2;
        FUNC_SYNC, FUNC_WRITING, FUNC_FAIL: span_max = 2 * pr_fast + 2;
        default:                           span_max = 2 * pr_slow + 2;
      endcase
      repeat (run_len) begin
        case ($urandom_range(9))
          0:       delta = '0;
          8:       delta = $urandom_range(0, 300);
          9:       delta = $urandom;
          default: delta = $urandom_range(0, span_max);
        endcase
        tick_cur = tick_cur + delta;
        this_func = ($urandom_range(99) < 4) ? las_func_t'($urandom_range(7)) : func;
        queue_poll(this_func, tick_cur);
        made++;
      end
    end
  endtask

  initial begin
    // The predictor starts from the block's reset state.
    pr_count = '0;
    pr_last = '0;
    pr_leds = '0;
    pr_slow = SLOW_STEP_RST;
    pr_medium = MEDIUM_STEP_RST;
    pr_fast = FAST_STEP_RST;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed walk under the reset step times (500, 200, 100). Success runs
    // through all four patterns and then past the last one, which restarts
    // the count without touching the LEDs. Waiting and sync show the same
    // restart, each mode is visited, the step boundary is probed with an
    // elapsed time equal to the step time and one beyond it, and the other
    // mode carries the count across the 32-bit tick wrap.
    queue_poll(FUNC_RESET,     32'd0);
    queue_poll(FUNC_SUCCESS,   32'd0);
    queue_poll(FUNC_SUCCESS,   32'd500);
    queue_poll(FUNC_SUCCESS,   32'd501);
    queue_poll(FUNC_SUCCESS,   32'd1002);
    queue_poll(FUNC_SUCCESS,   32'd1503);
    queue_poll(FUNC_SUCCESS,   32'd2004);
    queue_poll(FUNC_SUCCESS,   32'd2505);
    queue_poll(FUNC_WAITING,   32'd3006);
    queue_poll(FUNC_WAITING,   32'd3507);
    queue_poll(FUNC_RECEIVING, 32'd3508);
    queue_poll(FUNC_RECEIVING, 32'd3709);
    queue_poll(FUNC_SYNC,      32'd3710);
    queue_poll(FUNC_SYNC,      32'd3811);
    queue_poll(FUNC_SYNC,      32'd3912);
    queue_poll(FUNC_WRITING,   32'd3913);
    queue_poll(FUNC_WRITING,   32'd4014);
    queue_poll(FUNC_WRITING,   32'd4115);
    queue_poll(FUNC_FAIL,      32'd4116);
    queue_poll(FUNC_FAIL,      32'd4217);
    queue_poll(FUNC_FAIL,      32'd4318);
    queue_poll(FUNC_OTHER,     32'd4319);
    queue_poll(FUNC_OTHER,     32'hFFFF_FFFF);
    queue_poll(FUNC_OTHER,     32'h0000_01F3);
    queue_poll(FUNC_OTHER,     32'h0000_01F4);
    queue_poll(FUNC_RESET,     32'hFFFF_FFFF);
    wait_drained();

    // Short step times so that patterns cycle quickly; no idling.
    write_step_times(16'd20, 16'd10, 16'd5);
    tick_cur = $urandom;
    queue_random_polls(120);
    wait_drained();

    // All step times zero: every new tick is a step. A long run of the other
    // mode carries the counter past 255 and back to zero; one repeated tick
    // shows that a step needs a new tick. The unused index is written too.
    // The sender idles most of the time here.
    write_step_reg(CFG_UNUSED, 16'hFFFF);
    write_step_times(16'd0, 16'd0, 16'd0);
    send_idle_pct = 60;
    queue_poll(FUNC_RESET, tick_cur);
    queue_poll(FUNC_OTHER, tick_cur);
    repeat (260) begin
      tick_cur = tick_cur + 1;
      queue_poll(FUNC_OTHER, tick_cur);
    end
    queue_random_polls(60);
    wait_drained();

    // Longest step times, receiver stalling most of the time.
    write_step_reg(CFG_UNUSED, 16'h0000);
    write_step_times(16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_idle_pct = 0;
    recv_stall_pct = 60;
    queue_random_polls(100);
    wait_drained();

    // Random small step times, both sides idling now and then.
    write_step_times(STEP_W'($urandom_range(0, 40)), STEP_W'($urandom_range(0, 40)),
                     STEP_W'($urandom_range(0, 40)));
    write_step_reg(CFG_UNUSED, STEP_W'($urandom));
    send_idle_pct = 14;
    recv_stall_pct = 14;
    queue_random_polls(120);
    wait_drained();

    // Back-pressure: the receiver holds off for a long stretch while the
    // sender keeps offering polls, so the block fills and stalls its input.
    write_step_times(16'd7, 16'd3, 16'd1);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    @(posedge clk);
    hold_req = 1'b1;
    queue_random_polls(60);
    wait_drained();

    repeat (4) @(posedge clk);
    $display("Polls taken: %0d, LED results checked: %0d, register writes: %0d.",
             polls_taken, results_checked, cfg_writes);
    $display("Covered every mode, step times from 0 to 65535, tick wrap and idling on both sides.");
    if (mismatches == 0 && led_q.size() == 0) begin
      $display("led_animation_sequencer_top_test: PASS");
    end else begin
      if (led_q.size() != 0) begin
        $display("%0t: %0d LED results never arrived", $time, led_q.size());
      end
      $display("led_animation_sequencer_top_test: FAIL");
    end
    $finish;
  end

endmodule
